### rtl/core/shfc_pkg.sv
`default_nettype none

package shfc_pkg;

	localparam int unsigned SYNC_RUN           = 6;
	localparam int unsigned DATA_FRAME_LEN     = 1248;
	localparam int unsigned POSITION_FRAME_LEN = 554;

	localparam int unsigned OFF_W = 11;
	localparam int unsigned ST_W  = 3;

	// header check points
	localparam logic [OFF_W-1:0] DATA_MARK_OFF  = 11'd42;
	localparam logic [OFF_W-1:0] KIND_CHECK_OFF = 11'd43;
	localparam logic [OFF_W-1:0] DATA_HEAD_END  = 11'd43;
	localparam logic [OFF_W-1:0] POS_HEAD_END   = 11'd253;
	localparam logic [OFF_W-1:0] TAG_FIRST_OFF  = 11'd248;
	localparam logic [OFF_W-1:0] TAG_LAST_OFF   = 11'd253;

	localparam logic [7:0] SYNC_BYTE  = 8'hFF;
	localparam logic [7:0] DATA_MARK  = 8'hFF;
	localparam logic [7:0] DATA_TYPE  = 8'hEE;
	localparam logic [7:0] POS_TYPE   = 8'h00;

	// frame kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_POS  = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] ST_TENT = 3'd0;
	localparam logic [ST_W-1:0] ST_CONF = 3'd1;
	localparam logic [ST_W-1:0] ST_REJ  = 3'd2;
	localparam logic [ST_W-1:0] ST_BODY = 3'd3;
	localparam logic [ST_W-1:0] ST_LAST = 3'd4;
	localparam logic [ST_W-1:0] ST_END  = 3'd5;

	// register index
	localparam logic REG_PACKET_KIND = 1'b0;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [OFF_W-1:0] offset;
		logic [7:0]       frame_byte;
	} result_t;

	// "$GPRMC", indexed from the first tag offset
	function automatic logic [7:0] gprmc_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/shfc_front.sv
`default_nettype none

module shfc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       stream_byte,
	input  wire logic             stream_end,
	input  wire logic             packet_kind,
	output logic                  push,
	output shfc_pkg::result_t     item
);
	import shfc_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEAD,
		PH_BODY,
		PH_SKIP
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       sync_run_q, sync_run_d;
	logic [OFF_W-1:0] frame_offset_q, frame_offset_d;
	logic             check_failed_q, check_failed_d;

	logic [OFF_W-1:0] head_end;
	logic [OFF_W:0]   frame_len;
	logic [OFF_W:0]   off_next_w;
	logic [OFF_W-1:0] tag_idx;
	logic [2:0]       run_inc;
	logic             fails;
	logic             emit;

	assign head_end   = (packet_kind == KIND_DATA) ? DATA_HEAD_END : POS_HEAD_END;
	assign frame_len  = (packet_kind == KIND_DATA) ? (OFF_W+1)'(DATA_FRAME_LEN)
	                                               : (OFF_W+1)'(POSITION_FRAME_LEN);
	assign off_next_w = {1'b0, frame_offset_q} + (OFF_W+1)'(1);
	assign tag_idx    = frame_offset_q - TAG_FIRST_OFF;
	assign run_inc    = sync_run_q + 3'd1;

	always_comb begin
		fails = 1'b0;
		if (packet_kind == KIND_DATA) begin
			if (frame_offset_q == DATA_MARK_OFF)
				fails = (stream_byte != DATA_MARK);
			else if (frame_offset_q == KIND_CHECK_OFF)
				fails = (stream_byte != DATA_TYPE);
		end else begin
			if (frame_offset_q == KIND_CHECK_OFF)
				fails = (stream_byte != POS_TYPE);
			else if (frame_offset_q inside {[TAG_FIRST_OFF:TAG_LAST_OFF]})
				fails = (stream_byte != gprmc_char(tag_idx[2:0]));
		end
	end

	always_comb begin
		phase_d        = phase_q;
		sync_run_d     = sync_run_q;
		frame_offset_d = frame_offset_q;
		check_failed_d = check_failed_q;
		emit           = 1'b0;
		item.frame_byte = stream_byte;
		item.offset     = frame_offset_q;
		item.status     = ST_TENT;
		if (stream_end) begin
			phase_d        = PH_HUNT;
			sync_run_d     = '0;
			frame_offset_d = '0;
			check_failed_d = 1'b0;
			emit           = 1'b1;
			item.frame_byte = '0;
			item.offset     = '0;
			item.status     = ST_END;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (stream_byte == SYNC_BYTE) begin
						sync_run_d = run_inc;
						if (run_inc >= 3'(SYNC_RUN)) begin
							phase_d        = PH_HEAD;
							frame_offset_d = OFF_W'(SYNC_RUN);
							check_failed_d = 1'b0;
						end
					end else begin
						sync_run_d = '0;
					end
				end
				PH_HEAD: begin
					emit = 1'b1;
					if (fails)
						check_failed_d = 1'b1;
					if (frame_offset_q >= head_end) begin
						if (check_failed_q || fails) begin
							// rejected: full clear, hunt starts fresh
							item.status    = ST_REJ;
							phase_d        = PH_HUNT;
							sync_run_d     = '0;
							frame_offset_d = '0;
							check_failed_d = 1'b0;
						end else begin
							item.status    = ST_CONF;
							phase_d        = PH_BODY;
							frame_offset_d = off_next_w[OFF_W-1:0];
						end
					end else begin
						item.status    = ST_TENT;
						frame_offset_d = off_next_w[OFF_W-1:0];
					end
				end
				PH_BODY: begin
					emit = 1'b1;
					if (off_next_w >= frame_len) begin
						item.status    = ST_LAST;
						phase_d        = PH_SKIP;
						frame_offset_d = '0;
						sync_run_d     = '0;
					end else begin
						item.status    = ST_BODY;
						frame_offset_d = off_next_w[OFF_W-1:0];
					end
				end
				default: begin
					// byte after a finished frame is dropped
					phase_d        = PH_HUNT;
					sync_run_d     = '0;
					frame_offset_d = '0;
					check_failed_d = 1'b0;
				end
			endcase
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			sync_run_q     <= '0;
			frame_offset_q <= '0;
			check_failed_q <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			sync_run_q     <= sync_run_d;
			frame_offset_q <= frame_offset_d;
			check_failed_q <= check_failed_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/shfc_queue.sv
`default_nettype none

module shfc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire shfc_pkg::result_t push_item,
	input  wire logic              pop,
	output logic                   full,
	output logic                   not_empty,
	output shfc_pkg::result_t      head_item
);
	import shfc_pkg::*;

	result_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/core/shfc_back.sv
`default_nettype none

module shfc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire shfc_pkg::result_t q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output shfc_pkg::result_t      out_item
);
	import shfc_pkg::*;

	logic    valid_q;
	result_t item_q;

	// refill whenever the output word is empty or leaving
	assign q_pop     = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

endmodule

`default_nettype wire

### rtl/core/sync_hunt_frame_capture.sv
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: stream_byte; tlast: stream_end
// m_axis    out  tvalid/tready           tdata: frame_byte, offset; tuser: status
// apb       in   psel/penable/pready     reg 0 packet_kind at byte address 0
//
// One byte a cycle sustained while the queue has room; the front FSM decides each
// byte in the cycle it is taken, and a result is written into the queue and from
// there into the output register.
// s_axis_tready drops only while the 4-word queue is full (output stalled).
// Reset (arst_n low) returns to hunting, empties queue and output stage and
// clears packet_kind to data frames.
// packet_kind should be written only while the block is idle.

module sync_hunt_frame_capture (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	input  wire logic        s_axis_tlast,   // stream_end
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] frame_byte, [18:8] offset, rest zero
	output logic [2:0]       m_axis_tuser,   // [2:0] status
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import shfc_pkg::*;

	logic    packet_kind_q;
	logic    s_accept;
	logic    push;
	result_t push_item;
	logic    q_full;
	logic    q_not_empty;
	logic    q_pop;
	result_t head_item;
	result_t out_item;

	// --- config register ---
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PACKET_KIND) ? {31'b0, packet_kind_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			packet_kind_q <= KIND_DATA;
		else if (psel && penable && pwrite && pready && (paddr[2] == REG_PACKET_KIND))
			packet_kind_q <= pwdata[0];
	end

	// --- front: hunt / classify ---
	assign s_axis_tready = !q_full;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	shfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_accept),
		.stream_byte (s_axis_tdata),
		.stream_end  (s_axis_tlast),
		.packet_kind (packet_kind_q),
		.push        (push),
		.item        (push_item)
	);

	// --- decoupling queue ---
	shfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	// --- back: output word register ---
	shfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {5'b0, out_item.offset, out_item.frame_byte};
	assign m_axis_tuser = out_item.status;

	// --- checks ---
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("queue overrun");

	a_end_reported: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_axis_tlast |=> q_not_empty || m_axis_tvalid)
		else $error("end of stream word lost");

	a_end_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_END) |-> (m_axis_tdata == 24'b0))
		else $error("end word carries data");

	a_pop_only_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty && (!m_axis_tvalid || m_axis_tready))
		else $error("output word overwritten");

endmodule

`default_nettype wire
